// ----- rtl/core/dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// Date-time text parser package
// Shared payload types, text layout constants and small helper functions.
// ----------------------------------------------------------------------------
package dtp_pkg;

   localparam int PosWidth = 5;
   localparam int AccWidth = 7;
   localparam int YearWideWidth = 14;

   // Byte positions inside the text YYYY-MM-DD HH:MM:SS.
   localparam logic [PosWidth-1:0] PosYearHighEnd = 5'd1;
   localparam logic [PosWidth-1:0] PosYearLowEnd  = 5'd3;
   localparam logic [PosWidth-1:0] PosDash1       = 5'd4;
   localparam logic [PosWidth-1:0] PosMonthEnd    = 5'd6;
   localparam logic [PosWidth-1:0] PosDash2       = 5'd7;
   localparam logic [PosWidth-1:0] PosDayEnd      = 5'd9;
   localparam logic [PosWidth-1:0] PosSpace       = 5'd10;
   localparam logic [PosWidth-1:0] PosHourEnd     = 5'd12;
   localparam logic [PosWidth-1:0] PosColon1      = 5'd13;
   localparam logic [PosWidth-1:0] PosMinuteEnd   = 5'd15;
   localparam logic [PosWidth-1:0] PosColon2      = 5'd16;
   localparam logic [PosWidth-1:0] PosLast        = 5'd18;
   localparam logic [PosWidth-1:0] TextLen        = 5'd19;
   localparam logic [PosWidth-1:0] PosMax         = 5'd31;

   localparam logic [7:0] CharDash  = 8'h2D;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;

   localparam logic [YearWideWidth-1:0] YearMax = 14'd2099;
   localparam logic [YearWideWidth-1:0] Century = 14'd100;

   localparam int QueueDepthDefault = 2;

   typedef struct packed {
      logic [7:0] char_in;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic        valid_res;
      logic [11:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
   } rsp_type;

   // One parsed text waiting for range checks.
   typedef struct packed {
      logic                format_ok;
      logic [AccWidth-1:0] year_high;
      logic [AccWidth-1:0] year_low;
      logic [AccWidth-1:0] month;
      logic [AccWidth-1:0] day;
      logic [AccWidth-1:0] hour;
      logic [AccWidth-1:0] minute;
      logic [AccWidth-1:0] second;
   } record_type;

   function automatic logic [AccWidth-1:0] push_digit(input logic [AccWidth-1:0] acc,
                                                      input logic [3:0] digit);
      logic [AccWidth+3:0] sum;
      sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{AccWidth{1'b0}}, digit};
      return sum[AccWidth-1:0];
   endfunction

   function automatic logic [4:0] days_in(input logic [AccWidth-1:0] month,
                                          input logic leap);
      logic [4:0] days;
      case (month)
         7'd2:    days = leap ? 5'd29 : 5'd28;
         7'd4:    days = 5'd30;
         7'd6:    days = 5'd30;
         7'd9:    days = 5'd30;
         7'd11:   days = 5'd30;
         default: days = 5'd31;
      endcase
      return days;
   endfunction

endpackage

// ----- rtl/core/dtp_front.sv -----
// ----------------------------------------------------------------------------
// Date-time text parser front end
// Accepts characters, checks separators and digits, accumulates the fields.
// ----------------------------------------------------------------------------
module dtp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  dtp_pkg::req_type    req_data,
   input  logic                queue_full,
   output logic                push,
   output dtp_pkg::record_type push_data
);

   logic [dtp_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic [dtp_pkg::AccWidth-1:0] yh_ff, yh_in, yl_ff, yl_in, mo_ff, mo_in, dy_ff, dy_in;
   logic [dtp_pkg::AccWidth-1:0] hr_ff, hr_in, mi_ff, mi_in, se_ff, se_in;
   logic                         err_ff, err_in;

   logic [dtp_pkg::AccWidth-1:0] yh_u, yl_u, mo_u, dy_u, hr_u, mi_u, se_u;
   logic                         err_u;
   logic                         accept, is_digit;
   logic [7:0]                   ch;
   logic [3:0]                   dv;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign ch        = req_data.char_in;
   assign is_digit  = (ch >= dtp_pkg::CharZero) && (ch <= dtp_pkg::CharNine);
   assign dv        = ch[3:0];

   always_comb begin
      yh_u  = yh_ff;
      yl_u  = yl_ff;
      mo_u  = mo_ff;
      dy_u  = dy_ff;
      hr_u  = hr_ff;
      mi_u  = mi_ff;
      se_u  = se_ff;
      err_u = err_ff;
      if (pos_ff >= dtp_pkg::TextLen) begin
         err_u = 1'b1;
      end else if (pos_ff == dtp_pkg::PosDash1 || pos_ff == dtp_pkg::PosDash2) begin
         if (ch != dtp_pkg::CharDash) err_u = 1'b1;
      end else if (pos_ff == dtp_pkg::PosSpace) begin
         if (ch != dtp_pkg::CharSpace) err_u = 1'b1;
      end else if (pos_ff == dtp_pkg::PosColon1 || pos_ff == dtp_pkg::PosColon2) begin
         if (ch != dtp_pkg::CharColon) err_u = 1'b1;
      end else if (!is_digit) begin
         err_u = 1'b1;
      end else if (pos_ff <= dtp_pkg::PosYearHighEnd) begin
         yh_u = dtp_pkg::push_digit(yh_ff, dv);
      end else if (pos_ff <= dtp_pkg::PosYearLowEnd) begin
         yl_u = dtp_pkg::push_digit(yl_ff, dv);
      end else if (pos_ff <= dtp_pkg::PosMonthEnd) begin
         mo_u = dtp_pkg::push_digit(mo_ff, dv);
      end else if (pos_ff <= dtp_pkg::PosDayEnd) begin
         dy_u = dtp_pkg::push_digit(dy_ff, dv);
      end else if (pos_ff <= dtp_pkg::PosHourEnd) begin
         hr_u = dtp_pkg::push_digit(hr_ff, dv);
      end else if (pos_ff <= dtp_pkg::PosMinuteEnd) begin
         mi_u = dtp_pkg::push_digit(mi_ff, dv);
      end else begin
         se_u = dtp_pkg::push_digit(se_ff, dv);
      end
   end

   always_comb begin
      pos_in = pos_ff;
      yh_in  = yh_ff;
      yl_in  = yl_ff;
      mo_in  = mo_ff;
      dy_in  = dy_ff;
      hr_in  = hr_ff;
      mi_in  = mi_ff;
      se_in  = se_ff;
      err_in = err_ff;
      if (accept && req_data.is_last) begin
         // The text is complete: start over for the next one.
         pos_in = '0;
         yh_in  = '0;
         yl_in  = '0;
         mo_in  = '0;
         dy_in  = '0;
         hr_in  = '0;
         mi_in  = '0;
         se_in  = '0;
         err_in = 1'b0;
      end else if (accept) begin
         pos_in = (pos_ff == dtp_pkg::PosMax) ? pos_ff : pos_ff + 5'd1;
         yh_in  = yh_u;
         yl_in  = yl_u;
         mo_in  = mo_u;
         dy_in  = dy_u;
         hr_in  = hr_u;
         mi_in  = mi_u;
         se_in  = se_u;
         err_in = err_u;
      end
   end

   assign push                = accept && req_data.is_last;
   assign push_data.format_ok = !err_u && (pos_ff == dtp_pkg::PosLast);
   assign push_data.year_high = yh_u;
   assign push_data.year_low  = yl_u;
   assign push_data.month     = mo_u;
   assign push_data.day       = dy_u;
   assign push_data.hour      = hr_u;
   assign push_data.minute    = mi_u;
   assign push_data.second    = se_u;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         yh_ff  <= '0;
         yl_ff  <= '0;
         mo_ff  <= '0;
         dy_ff  <= '0;
         hr_ff  <= '0;
         mi_ff  <= '0;
         se_ff  <= '0;
         err_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         yh_ff  <= yh_in;
         yl_ff  <= yl_in;
         mo_ff  <= mo_in;
         dy_ff  <= dy_in;
         hr_ff  <= hr_in;
         mi_ff  <= mi_in;
         se_ff  <= se_in;
         err_ff <= err_in;
      end
   end

endmodule

// ----- rtl/core/dtp_queue.sv -----
// ----------------------------------------------------------------------------
// Date-time text parser record queue
// Small FIFO of parsed records between the front end and the checker.
// ----------------------------------------------------------------------------
module dtp_queue #(
   parameter int Depth = dtp_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dtp_pkg::record_type push_data,
   input  logic                pop,
   output logic                not_empty,
   output logic                full,
   output dtp_pkg::record_type head_data
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastIdx = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(Depth);

   dtp_pkg::record_type  mem_ff [Depth];
   logic [PtrWidth-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;

   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == FullCnt);
   assign head_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LastIdx) ? '0 : wr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LastIdx) ? '0 : rd_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= FullCnt)
      else $error("record queue count exceeds its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("record pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("record popped from an empty queue");

   a_push_seen: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> not_empty)
      else $error("pushed record not visible at the queue head");

endmodule

// ----- rtl/core/dtp_back.sv -----
// ----------------------------------------------------------------------------
// Date-time text parser back end
// Range-checks one parsed record and holds the result until it is taken.
// ----------------------------------------------------------------------------
module dtp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                rec_valid,
   input  dtp_pkg::record_type rec_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dtp_pkg::rsp_type    rsp_data
);

   logic                              rsp_valid_ff, rsp_valid_in;
   dtp_pkg::rsp_type                  rsp_ff, rsp_in;
   logic [dtp_pkg::YearWideWidth-1:0] year;
   logic                              leap, ok;

   assign pop  = rec_valid && (!rsp_valid_ff || rsp_ready);

   // Year = high * 100 + low. Both halves are two-digit values whenever the
   // format passed, so the leap rule reduces to checks on the two halves.
   assign year = dtp_pkg::YearWideWidth'(rec_data.year_high) * dtp_pkg::Century
               + dtp_pkg::YearWideWidth'(rec_data.year_low);
   assign leap = (rec_data.year_low[1:0] == 2'b00)
              && ((rec_data.year_low != '0) || (rec_data.year_high[1:0] == 2'b00));

   always_comb begin
      ok = rec_data.format_ok
        && (year != '0) && (year <= dtp_pkg::YearMax)
        && (rec_data.month >= 7'd1) && (rec_data.month <= 7'd12)
        && (rec_data.day >= 7'd1)
        && (rec_data.day <= {2'b00, dtp_pkg::days_in(rec_data.month, leap)})
        && (rec_data.hour <= 7'd23)
        && (rec_data.minute <= 7'd59)
        && (rec_data.second <= 7'd59);
      rsp_in.valid_res  = ok;
      rsp_in.year_out   = ok ? year[11:0] : '0;
      rsp_in.month_out  = ok ? rec_data.month[3:0] : '0;
      rsp_in.day_out    = ok ? rec_data.day[4:0] : '0;
      rsp_in.hour_out   = ok ? rec_data.hour[4:0] : '0;
      rsp_in.minute_out = ok ? rec_data.minute[5:0] : '0;
      rsp_in.second_out = ok ? rec_data.second[5:0] : '0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.valid_res) |-> (rsp_ff.year_out == '0
         && rsp_ff.month_out == '0 && rsp_ff.day_out == '0 && rsp_ff.hour_out == '0
         && rsp_ff.minute_out == '0 && rsp_ff.second_out == '0))
      else $error("invalid result carries nonzero fields");

   a_valid_month: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.valid_res) |-> (rsp_ff.month_out != '0
         && rsp_ff.day_out != '0 && rsp_ff.year_out != '0))
      else $error("valid result with a zero year, month or day");

   a_pop_loads: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped record did not reach the result register");

endmodule

// ----- rtl/core/datetime_text_parser_validator.sv -----
// ----------------------------------------------------------------------------
// Date-time text parser and validator
// Parses YYYY-MM-DD HH:MM:SS text one character per item and checks it.
// ----------------------------------------------------------------------------
// The block takes one ASCII character per item, with is_last set on the final
// character of a text, and sustains one character per clock cycle while
// its queue is not full. Each text yields exactly one result. The front end
// folds the character into the running fields in the cycle it is accepted.
// The completed record is written into a small queue and, once the output
// register is free, the back end range-checks it (year 1..2099, month
// 1..12, day within the month with the Gregorian leap rule, hour 0..23,
// minute and second 0..59) and loads the result into that register, from
// which it goes valid on the result port. A result that fails any check,
// including a wrong length, a wrong separator or a non-digit, reports
// valid_res low with all fields zero. Characters keep flowing while results
// wait; the block stops taking characters only when QueueDepth parsed texts
// are waiting for a result slot.
// ----------------------------------------------------------------------------
module datetime_text_parser_validator #(
   parameter int QueueDepth = dtp_pkg::QueueDepthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dtp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dtp_pkg::rsp_type rsp_data
);

   // Record path between the front end, the queue and the back end.
   logic                push;
   dtp_pkg::record_type push_data;
   logic                pop;
   logic                queue_not_empty;
   logic                queue_full;
   dtp_pkg::record_type head_data;

   // The front end checks each character against its position in the text
   // and pushes one record per completed text.
   dtp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // The queue lets the front end keep accepting while a result is stalled.
   dtp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .full      (queue_full),
      .head_data (head_data)
   );

   // The back end applies the calendar and clock range checks.
   dtp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (queue_not_empty),
      .rec_data  (head_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- bench/datetime_text_parser_validator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Date-time text parser and validator testbench
// Streams YYYY-MM-DD HH:MM:SS texts into the parser one character per item,
// predicts the result of every text in step with the accepted characters, and
// compares each returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module datetime_text_parser_validator_test;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   dtp_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   dtp_pkg::rsp_type rsp_data;

   datetime_text_parser_validator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Upper bounds for the random idle cycles on each side. The tests drop
   // them to zero now and then so that full-rate stretches are exercised too.
   int req_gap_max = 6;
   int rsp_stall_max = 6;

   int mismatch_count = 0;
   int chars_sent = 0;

   // Parse state of the text being received, mirroring what the block keeps.
   logic [4:0] cur_pos;
   logic [6:0] year_hi_acc;
   logic [6:0] year_lo_acc;
   logic [6:0] month_acc;
   logic [6:0] day_acc;
   logic [6:0] hour_acc;
   logic [6:0] minute_acc;
   logic [6:0] second_acc;
   logic       text_fault;

   // Results predicted for completed texts, oldest first.
   dtp_pkg::rsp_type expected_dates[$];
   dtp_pkg::rsp_type oldest_date;

   // Characters of the text that the next send will stream out.
   logic [7:0] text_buf[$];

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The run must never take this long; a hang or a lost result ends here.
   initial begin
      #5ms;
      $display("datetime_text_parser_validator_test: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic logic [6:0] shift_in_digit(input logic [6:0] acc, input logic [3:0] d);
      int wide;
      wide = int'(acc) * 10 + int'(d);
      return wide[6:0];
   endfunction

   function automatic int month_length(input int year, input int month);
      logic leap;
      leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
      case (month)
         2:       return leap ? 29 : 28;
         4, 6, 9, 11: return 30;
         default: return 31;
      endcase
   endfunction

   task automatic clear_parse_state();
      cur_pos = '0;
      year_hi_acc = '0;
      year_lo_acc = '0;
      month_acc = '0;
      day_acc = '0;
      hour_acc = '0;
      minute_acc = '0;
      second_acc = '0;
      text_fault = 1'b0;
   endtask

   // Folds one accepted character into the parse state. On the last
   // character of a text the expected result is queued and the state cleared.
   task automatic parse_char(input logic [7:0] ch, input logic last);
      logic             is_digit;
      int               year;
      logic             ok;
      dtp_pkg::rsp_type outcome;
      is_digit = (ch >= dtp_pkg::CharZero) && (ch <= dtp_pkg::CharNine);
      if (cur_pos >= dtp_pkg::TextLen) begin
         // Anything past the nineteenth character makes the text too long.
         text_fault = 1'b1;
      end else if (cur_pos == dtp_pkg::PosDash1 || cur_pos == dtp_pkg::PosDash2) begin
         if (ch != dtp_pkg::CharDash) text_fault = 1'b1;
      end else if (cur_pos == dtp_pkg::PosSpace) begin
         if (ch != dtp_pkg::CharSpace) text_fault = 1'b1;
      end else if (cur_pos == dtp_pkg::PosColon1 || cur_pos == dtp_pkg::PosColon2) begin
         if (ch != dtp_pkg::CharColon) text_fault = 1'b1;
      end else if (!is_digit) begin
         // A bad digit flags the text but leaves the field untouched.
         text_fault = 1'b1;
      end else if (cur_pos <= dtp_pkg::PosYearHighEnd) begin
         year_hi_acc = shift_in_digit(year_hi_acc, ch[3:0]);
      end else if (cur_pos <= dtp_pkg::PosYearLowEnd) begin
         year_lo_acc = shift_in_digit(year_lo_acc, ch[3:0]);
      end else if (cur_pos <= dtp_pkg::PosMonthEnd) begin
         month_acc = shift_in_digit(month_acc, ch[3:0]);
      end else if (cur_pos <= dtp_pkg::PosDayEnd) begin
         day_acc = shift_in_digit(day_acc, ch[3:0]);
      end else if (cur_pos <= dtp_pkg::PosHourEnd) begin
         hour_acc = shift_in_digit(hour_acc, ch[3:0]);
      end else if (cur_pos <= dtp_pkg::PosMinuteEnd) begin
         minute_acc = shift_in_digit(minute_acc, ch[3:0]);
      end else begin
         second_acc = shift_in_digit(second_acc, ch[3:0]);
      end

      if (!last) begin
         if (cur_pos != dtp_pkg::PosMax) cur_pos = cur_pos + 5'd1;
      end else begin
         year = int'(year_hi_acc) * 100 + int'(year_lo_acc);
         ok = !text_fault && (cur_pos == dtp_pkg::PosLast);
         ok = ok && (year >= 1) && (year <= 2099);
         ok = ok && (month_acc >= 1) && (month_acc <= 12);
         ok = ok && (day_acc >= 1) && (int'(day_acc) <= month_length(year, int'(month_acc)));
         ok = ok && (hour_acc <= 23) && (minute_acc <= 59) && (second_acc <= 59);
         outcome = '0;
         if (ok) begin
            outcome.valid_res  = 1'b1;
            outcome.year_out   = year[11:0];
            outcome.month_out  = month_acc[3:0];
            outcome.day_out    = day_acc[4:0];
            outcome.hour_out   = hour_acc[4:0];
            outcome.minute_out = minute_acc[5:0];
            outcome.second_out = second_acc[5:0];
         end
         expected_dates.push_back(outcome);
         clear_parse_state();
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stalls on rsp_ready and the result checker.
   // ------------------------------------------------------------------------

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Before each result the receiver holds off for a random number of cycles,
   // then keeps ready high until that result has been taken.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_dates.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            mismatch_count++;
         end else begin
            oldest_date = expected_dates.pop_front();
            check_field("valid_res", int'(oldest_date.valid_res),
                        int'(rsp_data.valid_res));
            check_field("year_out", int'(oldest_date.year_out), int'(rsp_data.year_out));
            check_field("month_out", int'(oldest_date.month_out),
                        int'(rsp_data.month_out));
            check_field("day_out", int'(oldest_date.day_out), int'(rsp_data.day_out));
            check_field("hour_out", int'(oldest_date.hour_out), int'(rsp_data.hour_out));
            check_field("minute_out", int'(oldest_date.minute_out),
                        int'(rsp_data.minute_out));
            check_field("second_out", int'(oldest_date.second_out),
                        int'(rsp_data.second_out));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Character side
   // ------------------------------------------------------------------------

   // Sends one character as one item. It is entered at a falling edge and
   // returns at the falling edge after acceptance with valid still high, so
   // that the next call either keeps valid up or lowers it for its gap.
   task automatic send_char(input logic [7:0] ch, input logic last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{char_in: ch, is_last: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      parse_char(ch, last);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic load_text(input string s);
      int i;
      text_buf.delete();
      for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   // Streams the buffered text, flagging its final character.
   task automatic send_text();
      int i;
      for (i = 0; i < text_buf.size(); i++) send_char(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic send_string(input string s);
      load_text(s);
      send_text();
   endtask

   function automatic string stamp_string(input int y, input int mo, input int d,
                                          input int h, input int mi, input int s);
      return $sformatf("%04d-%02d-%02d %02d:%02d:%02d", y, mo, d, h, mi, s);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // The first and last valid instants, plus years just outside the range
   // and the largest value every field can hold.
   task automatic test_range_extremes();
      send_string("0001-01-01 00:00:00");
      send_string("2099-12-31 23:59:59");
      send_string("0000-06-15 12:30:30");
      send_string("2100-01-01 00:00:00");
      send_string("9999-99-99 99:99:99");
   endtask

   // February 29th only exists in leap years; centuries need a multiple of 400.
   task automatic test_leap_rule();
      send_string("2000-02-29 12:00:00");
      send_string("1900-02-29 12:00:00");
      send_string("2024-02-29 01:02:03");
      send_string("2023-02-29 01:02:03");
      send_string("2023-02-28 01:02:03");
      send_string("2023-04-31 10:10:10");
      send_string("2023-11-30 10:10:10");
   endtask

   // Each field one step outside its legal range while the others are fine.
   task automatic test_field_ranges();
      send_string("2023-00-10 10:10:10");
      send_string("2023-13-10 10:10:10");
      send_string("2023-05-00 10:10:10");
      send_string("2023-05-32 10:10:10");
      send_string("2023-05-10 24:10:10");
      send_string("2023-05-10 10:60:10");
      send_string("2023-05-10 10:10:60");
   endtask

   // Wrong separators, a letter and a dash in digit slots, and the zero and all-ones bytes.
   task automatic test_format_faults();
      send_string("2023/05-10 10:10:10");
      send_string("2023-05/10 10:10:10");
      send_string("2023-05-10T10:10:10");
      send_string("2023-05-10 10.10:10");
      send_string("2023-05-10 10:10.10");
      send_string("20a3-05-10 10:10:10");
      send_string("2023-05-10 10:10:1-");
      load_text("2023-05-10 10:10:10");
      text_buf[8] = 8'h00;
      send_text();
      load_text("2023-05-10 10:10:10");
      text_buf[2] = 8'hFF;
      send_text();
   endtask

   // Too short, one character only, too long, and long enough for the
   // position counter to saturate.
   task automatic test_length_faults();
      send_string("2023-05-10 10:10:1");
      send_string("7");
      send_string("2023-05-10 10:10:100");
      send_string({"2023-05-10 10:10:10", "2023-05-10 10:10:10", "2023"});
   endtask

   // Mostly well-formed texts with random fields near the limits; the rest
   // carry a corrupted byte, are cut short, run long, or are pure noise.
   task automatic random_text();
      int y, mo, d, h, mi, s;
      int kind;
      int n;
      int i;
      case ($urandom_range(0, 3))
         0:       y = $urandom_range(0, 9999);
         1:       y = $urandom_range(0, 99) * 100;
         2:       y = $urandom_range(1, 2099);
         default: y = $urandom_range(0, 524) * 4;
      endcase
      mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
      if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 99);
      else d = $urandom_range(0, month_length(y, (mo >= 1 && mo <= 12) ? mo : 1) + 1);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 24);
      mi = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
      load_text(stamp_string(y, mo, d, h, mi, s));
      kind = $urandom_range(0, 9);
      case (kind)
         7: text_buf[$urandom_range(0, 18)] = 8'($urandom_range(0, 255));
         8: begin
            n = $urandom_range(1, 18);
            while (text_buf.size() > n) void'(text_buf.pop_back());
         end
         9: begin
            if ($urandom_range(0, 1) == 0) begin
               n = $urandom_range(1, 6);
            end else begin
               text_buf.delete();
               n = $urandom_range(1, 36);
            end
            for (i = 0; i < n; i++) text_buf.push_back(8'($urandom_range(0, 255)));
         end
         default: ;
      endcase
      send_text();
   endtask

   task automatic test_random_texts();
      int stop_at;
      stop_at = chars_sent + 1200;
      while (chars_sent < stop_at) begin
         // About one text in four runs with no idling on either side.
         if ($urandom_range(0, 3) == 0) begin
            req_gap_max = 0;
            rsp_stall_max = 0;
         end else begin
            req_gap_max = 6;
            rsp_stall_max = 6;
         end
         random_text();
      end
      req_gap_max = 6;
      rsp_stall_max = 6;
   endtask

   // Full-rate texts, then short texts with results taken at once and then with stalls,
   // so that parsed texts pile up in the block while results are still being issued.
   task automatic test_back_to_back();
      int i;
      req_gap_max = 0;
      rsp_stall_max = 0;
      for (i = 0; i < 8; i++) send_string(stamp_string(2000 + i, 2, 29, 23, 59, 59));
      for (i = 0; i < 8; i++) send_string("1");
      rsp_stall_max = 6;
      for (i = 0; i < 12; i++) send_string("12");
      req_gap_max = 6;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      clear_parse_state();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_range_extremes();
      test_leap_rule();
      test_field_ranges();
      test_format_faults();
      test_length_faults();
      test_back_to_back();
      test_random_texts();

      req_valid <= 1'b0;
      while (expected_dates.size() != 0) @(negedge clock);
      // Let any stray result surface before the verdict.
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("datetime_text_parser_validator_test: done, clean");
      end else begin
         $display("datetime_text_parser_validator_test: done, errors");
      end
      $finish;
   end

endmodule
